### rtl/spq_pkg.sv
// Shared types and constants of the sorted priority queue.
// No dependencies; used by every file under rtl/.
package spq_pkg;

    localparam int DATA_W           = 32;
    localparam int OCC_W            = 5;
    localparam int DEFAULT_CAPACITY = 16;

    // Input tuser: request kind
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    // Output tuser: result status
    localparam logic [1:0] STATUS_DONE      = 2'd0;
    localparam logic [1:0] STATUS_POP_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_PUSH_FULL = 2'd2;

    // Stream payload widths
    localparam int S_TDATA_W = 2 * DATA_W;
    localparam int M_FIELD_W = 2 * DATA_W + OCC_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    typedef struct packed {
        logic signed [DATA_W-1:0] prio;
        logic signed [DATA_W-1:0] value;
    } t_entry;

    // Broadcast to every cell each cycle
    typedef struct packed {
        logic   push;
        logic   pop;
        t_entry new_entry;
    } t_cell_ctrl;

endpackage

### rtl/spq_cell.sv
// One storage cell of the sorted priority queue chain.
// Depends on spq_pkg (t_entry, t_cell_ctrl).
module spq_cell (
    input  logic                i_clk,
    input  spq_pkg::t_cell_ctrl i_ctrl,
    input  logic                i_valid,       // cell index below entry count
    input  spq_pkg::t_entry     i_left,        // neighbor nearer the head
    input  logic                i_left_behind, // new entry goes behind left neighbor
    input  spq_pkg::t_entry     i_right,       // neighbor nearer the tail
    output spq_pkg::t_entry     o_entry,
    output logic                o_behind       // new entry goes behind this cell
);

    spq_pkg::t_entry r_entry;
    spq_pkg::t_entry n_entry;

    // Equal priority keeps the stored entry ahead (arrival order)
    assign o_behind = i_valid && (r_entry.prio >= i_ctrl.new_entry.prio);
    assign o_entry  = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.push) begin
            if (!o_behind) begin
                n_entry = i_left_behind ? i_ctrl.new_entry : i_left;
            end
        end else if (i_ctrl.pop) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

### rtl/sorted_priority_queue_unit.sv
// Sorted priority queue: top level, a chain of spq_cell storage cells.
// Depends on spq_pkg and spq_cell.
//
// Bounded priority queue of CAPACITY entries kept sorted by descending signed
// priority in a chain of cells, head in cell 0. Every input item is a push
// (tuser = 0) or a pop (tuser = 1) and produces exactly one result item. A
// push compares its priority against all cells at once; each cell decides
// locally to keep its entry, take the new one or take its left neighbor's,
// so the insert is a single shift. Entries of equal priority leave in
// arrival order. A pop shifts every cell one place toward the head. A push
// into a full queue is dropped with status 2; a pop on an empty queue
// returns status 1. Value and priority are zero unless a pop succeeded.
// Occupancy after the operation is reported in 5 bits (low bits if
// CAPACITY is larger). Rate: one item per clock unless the output stalls;
// the path is one 32-bit signed compare per cell plus the cell's select.
// The result sits in an output register, so a new item is taken whenever
// that register is empty or being drained. No clearing pass after reset.
module sorted_priority_queue_unit #(
    parameter int CAPACITY = spq_pkg::DEFAULT_CAPACITY
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input stream
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [spq_pkg::S_TDATA_W-1:0] i_s_axis_tdata,  // [31:0] value, [63:32] priority_req
    input  logic                          i_s_axis_tuser,  // [0] action
    // Result stream
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [spq_pkg::M_TDATA_W-1:0] o_m_axis_tdata,  // [31:0] out_value,
                                                           // [63:32] out_priority,
                                                           // [68:64] occupancy, rest zero
    output logic [1:0]                    o_m_axis_tuser   // [1:0] status
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

    // Entry count (fill count of the chain)
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    // Output register
    logic                            r_out_valid;
    spq_pkg::t_entry                 r_out_entry;
    spq_pkg::t_entry                 n_out_entry;
    logic [1:0]                      r_out_status;
    logic [1:0]                      n_out_status;
    logic [spq_pkg::OCC_W-1:0]       r_out_occ;

    logic                in_acc;
    logic                is_full;
    logic                is_empty;
    spq_pkg::t_cell_ctrl cell_ctrl;

    // Chain wiring
    spq_pkg::t_entry cell_entry  [CAPACITY];
    logic            cell_behind [CAPACITY];
    logic            cell_valid  [CAPACITY];

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign is_full         = (r_count == CNT_FULL);
    assign is_empty        = (r_count == '0);

    assign cell_ctrl.new_entry.value = i_s_axis_tdata[spq_pkg::DATA_W-1:0];
    assign cell_ctrl.new_entry.prio  = i_s_axis_tdata[2*spq_pkg::DATA_W-1:spq_pkg::DATA_W];
    assign cell_ctrl.push = in_acc && (i_s_axis_tuser == spq_pkg::ACT_PUSH) && !is_full;
    assign cell_ctrl.pop  = in_acc && (i_s_axis_tuser == spq_pkg::ACT_POP) && !is_empty;

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        localparam logic [CNT_W-1:0] IDX = CNT_W'(gi);

        spq_pkg::t_entry left_entry;
        spq_pkg::t_entry right_entry;
        logic            left_behind;

        assign cell_valid[gi] = (IDX < r_count);

        if (gi == 0) begin : g_head
            assign left_entry  = cell_ctrl.new_entry;
            assign left_behind = 1'b1;
        end else begin : g_body
            assign left_entry  = cell_entry[gi-1];
            assign left_behind = cell_behind[gi-1];
        end

        // Tail cell pulls in filler on pop; it lies beyond the count
        if (gi == CAPACITY - 1) begin : g_tail
            assign right_entry = cell_ctrl.new_entry;
        end else begin : g_mid
            assign right_entry = cell_entry[gi+1];
        end

        spq_cell u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (cell_ctrl),
            .i_valid       (cell_valid[gi]),
            .i_left        (left_entry),
            .i_left_behind (left_behind),
            .i_right       (right_entry),
            .o_entry       (cell_entry[gi]),
            .o_behind      (cell_behind[gi])
        );
    end

    always_comb begin
        n_count      = r_count;
        n_out_entry  = '0;
        n_out_status = spq_pkg::STATUS_DONE;
        if (cell_ctrl.push) begin
            n_count = r_count + 1'b1;
        end else if (cell_ctrl.pop) begin
            n_count     = r_count - 1'b1;
            n_out_entry = cell_entry[0];
        end else if (i_s_axis_tuser == spq_pkg::ACT_PUSH) begin
            n_out_status = spq_pkg::STATUS_PUSH_FULL;
        end else begin
            n_out_status = spq_pkg::STATUS_POP_EMPTY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (in_acc) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload, no reset
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out_entry  <= n_out_entry;
            r_out_status <= n_out_status;
            r_out_occ    <= spq_pkg::OCC_W'(n_count);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tdata  = spq_pkg::M_TDATA_W'({r_out_occ, r_out_entry.prio,
                                                   r_out_entry.value});

endmodule

### rtl/spq_checker.sv
// Port-level checks for sorted_priority_queue_unit, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue_unit.
module spq_checker #(
    parameter int CAPACITY = spq_pkg::DEFAULT_CAPACITY
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_axis_tvalid,
    input logic                          o_s_axis_tready,
    input logic                          o_m_axis_tvalid,
    input logic                          i_m_axis_tready,
    input logic [spq_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    input logic [1:0]                    o_m_axis_tuser
);

    localparam int OCC_LO = 2 * spq_pkg::DATA_W;

    logic [spq_pkg::OCC_W-1:0] occ;
    assign occ = o_m_axis_tdata[OCC_LO +: spq_pkg::OCC_W];

    // Stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata)
                                                && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    // Every accepted item shows a result next cycle
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> o_m_axis_tvalid)
        else $error("accepted item gave no result");

    // Pop on empty reports an empty queue and zero payload
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == spq_pkg::STATUS_POP_EMPTY)
        |-> (occ == '0) && (o_m_axis_tdata[OCC_LO-1:0] == '0))
        else $error("pop-empty result inconsistent");

    // Dropped push reports a full queue
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == spq_pkg::STATUS_PUSH_FULL)
        |-> (occ == spq_pkg::OCC_W'(CAPACITY)) && (o_m_axis_tdata[OCC_LO-1:0] == '0))
        else $error("push-full result inconsistent");

endmodule

bind sorted_priority_queue_unit spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (.*);
